FILE: sv/tpsg_pkg.sv
`default_nettype none

package tpsg_pkg;

  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int SINE_ADDR_W      = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int SINE_W           = 15;

  localparam int INDEX_W     = 16;
  localparam int ANGLE_W     = 32;
  localparam int AMP_W       = 22;
  localparam int SAMPLE_W    = 23;
  localparam int NEUTRAL_W   = 25;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 3;
  localparam int OUT_TDATA_W = 192;
  localparam int NUM_PHASES  = 6;

  localparam logic [ANGLE_W-1:0] THIRD_TURN  = 32'h5555_5555;
  localparam logic [ANGLE_W-1:0] HALF_PI_Q30 = 32'd1686629713;

  localparam logic [ANGLE_W-1:0] PHASE_STEP_RST  = 32'd53687091;
  localparam logic [ANGLE_W-1:0] CURRENT_LAG_RST = 32'd357913941;
  localparam logic [AMP_W-1:0]   VOLT_AMP_RST    = 22'd1555635;
  localparam logic [AMP_W-1:0]   CURR_AMP_RST    = 22'd14142;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_PHASE_STEP  = 3'd0,
    CFG_CURRENT_LAG = 3'd1,
    CFG_VOLT_AMP_A  = 3'd2,
    CFG_VOLT_AMP_B  = 3'd3,
    CFG_VOLT_AMP_C  = 3'd4,
    CFG_CURR_AMP_A  = 3'd5,
    CFG_CURR_AMP_B  = 3'd6,
    CFG_CURR_AMP_C  = 3'd7
  } cfg_idx_t;

  typedef logic [SINE_W-1:0] sine_rom_t [0:SINE_TABLE_DEPTH];

  // Quarter-wave sine in Q0.15: odd Taylor series to x^13 in Q30, rounded half up.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t          rom;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] acc;
    logic [63:0]        q;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      x    = (64'(i) * 64'(HALF_PI_Q30)) / SINE_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      acc  = $signed(x);
      term = ((term * x2) >> 30) / 6;
      acc  = acc - $signed(term);
      term = ((term * x2) >> 30) / 20;
      acc  = acc + $signed(term);
      term = ((term * x2) >> 30) / 42;
      acc  = acc - $signed(term);
      term = ((term * x2) >> 30) / 72;
      acc  = acc + $signed(term);
      term = ((term * x2) >> 30) / 110;
      acc  = acc - $signed(term);
      term = ((term * x2) >> 30) / 156;
      acc  = acc + $signed(term);
      if (acc < 0) begin
        acc = 0;
      end
      q = ($unsigned(acc) + 64'd16384) >> 15;
      if (q > 64'd32767) begin
        q = 64'd32767;
      end
      rom[i] = q[SINE_W-1:0];
    end
    return rom;
  endfunction

endpackage

`default_nettype wire

FILE: sv/tpsg_sine_rom.sv
`default_nettype none

module tpsg_sine_rom (
  input  wire logic                               clk,
  input  wire logic                               en,
  input  wire logic [tpsg_pkg::SINE_ADDR_W-1:0]   addr_a,
  input  wire logic [tpsg_pkg::SINE_ADDR_W-1:0]   addr_b,
  output logic      [tpsg_pkg::SINE_W-1:0]        data_a,
  output logic      [tpsg_pkg::SINE_W-1:0]        data_b
);

  localparam tpsg_pkg::sine_rom_t ROM = tpsg_pkg::build_sine_rom();

  always_ff @(posedge clk) begin
    if (en) begin
      data_a <= ROM[addr_a];
      data_b <= ROM[addr_b];
    end
  end

endmodule

`default_nettype wire

FILE: sv/three_phase_sine_generator.sv
// Channel | Dir | Handshake         | Payload
// in_     | in  | tvalid / tready   | tdata[15:0] sample_index
// out_    | out | tvalid / tready   | tdata[187:0] six samples and two neutral sums, zero padded to 192
// cfg_    | in  | wen               | addr[2:0] register index, wdata[31:0]
//
// One sample index per clock, unless the pipe is full while out_tready is low.
// The pipe has six stages: index multiply, angle adds,
// sine ROM read (three dual-port ROMs), amplitude multiply, sign, neutral sums.
// Synchronous reset clears the valid bits and loads the register defaults.
// A stage holds only while the stage after it is full and stalled, so
// bubbles fill in and input is still taken while a result waits.
`default_nettype none

module three_phase_sine_generator (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // sample_index[15:0]
  input  wire logic [tpsg_pkg::INDEX_W-1:0]        in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // volt_a[22:0], volt_b[45:23], volt_c[68:46], volt_neutral[93:69],
  // curr_a[116:94], curr_b[139:117], curr_c[162:140], curr_neutral[187:163], zeros
  output logic      [tpsg_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  wire logic                                cfg_wen,
  input  wire logic [tpsg_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [tpsg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int NP     = tpsg_pkg::NUM_PHASES;
  localparam int AW     = tpsg_pkg::SINE_ADDR_W;
  localparam int PROD_W = tpsg_pkg::AMP_W + tpsg_pkg::SINE_W;
  localparam int KP_W   = 30 + AW;
  localparam int SW     = tpsg_pkg::SAMPLE_W;
  localparam int NW     = tpsg_pkg::NEUTRAL_W;

  // configuration
  logic [tpsg_pkg::ANGLE_W-1:0] phase_step_r;
  logic [tpsg_pkg::ANGLE_W-1:0] current_lag_r;
  logic [tpsg_pkg::AMP_W-1:0]   amp_r [NP];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r  <= tpsg_pkg::PHASE_STEP_RST;
      current_lag_r <= tpsg_pkg::CURRENT_LAG_RST;
      amp_r[0]      <= tpsg_pkg::VOLT_AMP_RST;
      amp_r[1]      <= tpsg_pkg::VOLT_AMP_RST;
      amp_r[2]      <= tpsg_pkg::VOLT_AMP_RST;
      amp_r[3]      <= tpsg_pkg::CURR_AMP_RST;
      amp_r[4]      <= tpsg_pkg::CURR_AMP_RST;
      amp_r[5]      <= tpsg_pkg::CURR_AMP_RST;
    end else if (cfg_wen) begin
      unique case (tpsg_pkg::cfg_idx_t'(cfg_addr))
        tpsg_pkg::CFG_PHASE_STEP:  phase_step_r  <= cfg_wdata;
        tpsg_pkg::CFG_CURRENT_LAG: current_lag_r <= cfg_wdata;
        tpsg_pkg::CFG_VOLT_AMP_A:  amp_r[0] <= cfg_wdata[tpsg_pkg::AMP_W-1:0];
        tpsg_pkg::CFG_VOLT_AMP_B:  amp_r[1] <= cfg_wdata[tpsg_pkg::AMP_W-1:0];
        tpsg_pkg::CFG_VOLT_AMP_C:  amp_r[2] <= cfg_wdata[tpsg_pkg::AMP_W-1:0];
        tpsg_pkg::CFG_CURR_AMP_A:  amp_r[3] <= cfg_wdata[tpsg_pkg::AMP_W-1:0];
        tpsg_pkg::CFG_CURR_AMP_B:  amp_r[4] <= cfg_wdata[tpsg_pkg::AMP_W-1:0];
        tpsg_pkg::CFG_CURR_AMP_C:  amp_r[5] <= cfg_wdata[tpsg_pkg::AMP_W-1:0];
        default: ;
      endcase
    end
  end

  // stage enables: a stage loads when empty or when the next one loads
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic en1, en2, en3, en4, en5, en6;

  assign en6 = !v6_r || out_tready;
  assign en5 = !v5_r || en6;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_tready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_tvalid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
    end
  end

  // stage 1: base angle
  logic [tpsg_pkg::ANGLE_W-1:0] th1_r;
  logic [tpsg_pkg::ANGLE_W-1:0] th1_nxt;

  assign th1_nxt = {{(tpsg_pkg::ANGLE_W - tpsg_pkg::INDEX_W){1'b0}}, in_tdata} * phase_step_r;

  always_ff @(posedge clk) begin
    if (en1) th1_r <= th1_nxt;
  end

  // stage 2: six phase angles, voltages then currents
  logic [tpsg_pkg::ANGLE_W-1:0] ang2_r [NP];
  logic [tpsg_pkg::ANGLE_W-1:0] ti_nxt;

  assign ti_nxt = th1_r - current_lag_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      ang2_r[0] <= th1_r;
      ang2_r[1] <= th1_r - tpsg_pkg::THIRD_TURN;
      ang2_r[2] <= th1_r + tpsg_pkg::THIRD_TURN;
      ang2_r[3] <= ti_nxt;
      ang2_r[4] <= ti_nxt - tpsg_pkg::THIRD_TURN;
      ang2_r[5] <= ti_nxt + tpsg_pkg::THIRD_TURN;
    end
  end

  // stage 3: quadrant fold and ROM read
  logic [AW-1:0]              addr_nxt [NP];
  logic [tpsg_pkg::SINE_W-1:0] rom_q   [NP];
  logic                       neg3_r  [NP];

  always_comb begin
    for (int j = 0; j < NP; j++) begin
      logic [KP_W-1:0] kp;
      logic [AW-1:0]   k;
      kp = KP_W'(ang2_r[j][29:0]) * KP_W'(tpsg_pkg::SINE_TABLE_DEPTH);
      k  = kp[KP_W-1:30];
      addr_nxt[j] = ang2_r[j][30] ? (AW'(tpsg_pkg::SINE_TABLE_DEPTH) - k) : k;
    end
  end

  for (genvar g = 0; g < NP / 2; g++) begin : g_rom
    tpsg_sine_rom u_rom (
      .clk    (clk),
      .en     (en3),
      .addr_a (addr_nxt[2*g]),
      .addr_b (addr_nxt[2*g+1]),
      .data_a (rom_q[2*g]),
      .data_b (rom_q[2*g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      for (int j = 0; j < NP; j++) neg3_r[j] <= ang2_r[j][31];
    end
  end

  // stage 4: amplitude times |sine|, truncated
  logic [tpsg_pkg::AMP_W-1:0] mag4_r [NP];
  logic                       neg4_r [NP];

  always_ff @(posedge clk) begin
    if (en4) begin
      for (int j = 0; j < NP; j++) begin
        logic [PROD_W-1:0] p;
        p = PROD_W'(amp_r[j]) * PROD_W'(rom_q[j]);
        mag4_r[j] <= p[PROD_W-1:tpsg_pkg::SINE_W];
        neg4_r[j] <= neg3_r[j];
      end
    end
  end

  // stage 5: apply sign
  logic signed [SW-1:0] smp5_r [NP];

  always_ff @(posedge clk) begin
    if (en5) begin
      for (int j = 0; j < NP; j++) begin
        logic signed [SW-1:0] m;
        m = $signed({1'b0, mag4_r[j]});
        smp5_r[j] <= neg4_r[j] ? -m : m;
      end
    end
  end

  // stage 6: neutral sums and output register
  logic signed [SW-1:0] smp6_r [NP];
  logic signed [NW-1:0] vn6_r;
  logic signed [NW-1:0] cn6_r;

  always_ff @(posedge clk) begin
    if (en6) begin
      for (int j = 0; j < NP; j++) smp6_r[j] <= smp5_r[j];
      vn6_r <= NW'(smp5_r[0]) + NW'(smp5_r[1]) + NW'(smp5_r[2]);
      cn6_r <= NW'(smp5_r[3]) + NW'(smp5_r[4]) + NW'(smp5_r[5]);
    end
  end

  assign out_tvalid = v6_r;
  assign out_tdata  = {4'b0, cn6_r, smp6_r[5], smp6_r[4], smp6_r[3],
                       vn6_r, smp6_r[2], smp6_r[1], smp6_r[0]};

endmodule

`default_nettype wire

FILE: sv/tpsg_checker.sv
`default_nettype none

module tpsg_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tready,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [tpsg_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  logic signed [24:0] vsum;
  logic signed [24:0] csum;

  assign vsum = 25'($signed(out_tdata[22:0])) + 25'($signed(out_tdata[45:23]))
              + 25'($signed(out_tdata[68:46]));
  assign csum = 25'($signed(out_tdata[116:94])) + 25'($signed(out_tdata[139:117]))
              + 25'($signed(out_tdata[162:140]));

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // neutral values match their phases
  a_volt_neutral: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $signed(out_tdata[93:69]) == vsum)
    else $error("voltage neutral mismatch");

  a_curr_neutral: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $signed(out_tdata[187:163]) == csum)
    else $error("current neutral mismatch");

  // pipe empties on reset and shows ready after each reset edge
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("pipe not empty after reset");

  // with an empty output stage the pipe must take a request
  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("request refused with output free");

endmodule

bind three_phase_sine_generator tpsg_checker u_tpsg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

FILE: test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Same layout as out_tdata, lowest field last.
  typedef struct packed {
    logic [3:0]         pad;
    logic signed [24:0] curr_neutral;
    logic signed [22:0] curr_c;
    logic signed [22:0] curr_b;
    logic signed [22:0] curr_a;
    logic signed [24:0] volt_neutral;
    logic signed [22:0] volt_c;
    logic signed [22:0] volt_b;
    logic signed [22:0] volt_a;
  } sample_set_t;

  logic                                 clk;
  logic                                 rst_n      = 1'b0;
  logic                                 in_tvalid  = 1'b0;
  logic                                 in_tready;
  logic [tpsg_pkg::INDEX_W-1:0]         in_tdata   = '0;
  logic                                 out_tvalid;
  logic                                 out_tready = 1'b0;
  logic [tpsg_pkg::OUT_TDATA_W-1:0]     out_tdata;
  logic                                 cfg_wen    = 1'b0;
  tpsg_pkg::cfg_idx_t                   cfg_addr   = tpsg_pkg::CFG_PHASE_STEP;
  logic [tpsg_pkg::CFG_DATA_W-1:0]      cfg_wdata  = '0;

  three_phase_sine_generator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Register copies used by the sample predictor.
  logic [tpsg_pkg::ANGLE_W-1:0] step_cfg = tpsg_pkg::PHASE_STEP_RST;
  logic [tpsg_pkg::ANGLE_W-1:0] lag_cfg  = tpsg_pkg::CURRENT_LAG_RST;
  logic [tpsg_pkg::AMP_W-1:0]   volt_amp [3] = '{tpsg_pkg::VOLT_AMP_RST,
                                                 tpsg_pkg::VOLT_AMP_RST,
                                                 tpsg_pkg::VOLT_AMP_RST};
  logic [tpsg_pkg::AMP_W-1:0]   curr_amp [3] = '{tpsg_pkg::CURR_AMP_RST,
                                                 tpsg_pkg::CURR_AMP_RST,
                                                 tpsg_pkg::CURR_AMP_RST};

  int sine_tab [0:tpsg_pkg::SINE_TABLE_DEPTH];

  logic [tpsg_pkg::INDEX_W-1:0] index_q [$];
  sample_set_t                  sample_exp_q [$];

  bit req_taken;
  int burst_left;
  int gap_left;
  logic [7:0] ready_pat;
  int pat_left;
  int err_count;
  int req_count;
  int result_count;
  int setting_count = 1;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic void fill_sine_tab();
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    longint unsigned q15;
    for (int i = 0; i <= tpsg_pkg::SINE_TABLE_DEPTH; i++) begin
      x    = (longint'(i) * 64'd1686629713) / tpsg_pkg::SINE_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int k = 1; k <= 6; k++) begin
        term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      q15 = (longint'(acc) + 16384) >> 15;
      if (q15 > 32767) begin
        q15 = 32767;
      end
      sine_tab[i] = int'(q15);
    end
  endfunction

  // amp * sin(angle), magnitude truncated then signed.
  function automatic longint amp_sine(logic [tpsg_pkg::AMP_W-1:0] amp,
                                      logic [tpsg_pkg::ANGLE_W-1:0] angle);
    longint k;
    longint s;
    longint mag;
    k = (longint'(angle[29:0]) * tpsg_pkg::SINE_TABLE_DEPTH) >> 30;
    if (k > tpsg_pkg::SINE_TABLE_DEPTH) begin
      k = tpsg_pkg::SINE_TABLE_DEPTH;
    end
    s   = angle[30] ? sine_tab[tpsg_pkg::SINE_TABLE_DEPTH - k] : sine_tab[k];
    mag = (longint'(amp) * s) >> 15;
    return angle[31] ? -mag : mag;
  endfunction

  function automatic sample_set_t predict_samples(logic [tpsg_pkg::INDEX_W-1:0] index);
    logic [tpsg_pkg::ANGLE_W-1:0] th;
    logic [tpsg_pkg::ANGLE_W-1:0] ti;
    longint va, vb, vc, ia, ib, ic;
    sample_set_t r;
    th = {{(tpsg_pkg::ANGLE_W - tpsg_pkg::INDEX_W){1'b0}}, index} * step_cfg;
    ti = th - lag_cfg;
    va = amp_sine(volt_amp[0], th);
    vb = amp_sine(volt_amp[1], th - tpsg_pkg::THIRD_TURN);
    vc = amp_sine(volt_amp[2], th + tpsg_pkg::THIRD_TURN);
    ia = amp_sine(curr_amp[0], ti);
    ib = amp_sine(curr_amp[1], ti - tpsg_pkg::THIRD_TURN);
    ic = amp_sine(curr_amp[2], ti + tpsg_pkg::THIRD_TURN);
    r.pad          = '0;
    r.volt_a       = va[22:0];
    r.volt_b       = vb[22:0];
    r.volt_c       = vc[22:0];
    r.volt_neutral = 25'(va + vb + vc);
    r.curr_a       = ia[22:0];
    r.curr_b       = ib[22:0];
    r.curr_c       = ic[22:0];
    r.curr_neutral = 25'(ia + ib + ic);
    return r;
  endfunction

  task automatic flag_error(string msg);
    err_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic cmp_field(string name, longint got, longint want);
    if (got != want) begin
      flag_error($sformatf("result %0d %s got %0d want %0d", result_count, name, got, want));
    end
  endtask

  // Monitor: record accepted requests, check accepted results.
  always @(posedge clk) begin
    sample_set_t got;
    sample_set_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = sample_set_t'(out_tdata);
      if (sample_exp_q.size() == 0) begin
        flag_error("result with no request pending");
      end else begin
        want = sample_exp_q.pop_front();
        cmp_field("volt_a", got.volt_a, want.volt_a);
        cmp_field("volt_b", got.volt_b, want.volt_b);
        cmp_field("volt_c", got.volt_c, want.volt_c);
        cmp_field("volt_neutral", got.volt_neutral, want.volt_neutral);
        cmp_field("curr_a", got.curr_a, want.curr_a);
        cmp_field("curr_b", got.curr_b, want.curr_b);
        cmp_field("curr_c", got.curr_c, want.curr_c);
        cmp_field("curr_neutral", got.curr_neutral, want.curr_neutral);
        cmp_field("padding", got.pad, want.pad);
      end
      result_count++;
    end
    req_taken = rst_n && in_tvalid && in_tready;
    if (req_taken) begin
      sample_exp_q.push_back(predict_samples(in_tdata));
      req_count++;
    end
  end

  // Driver: bursts of requests separated by random gaps.
  always @(negedge clk) begin
    logic                         next_valid;
    logic [tpsg_pkg::INDEX_W-1:0] next_index;
    next_valid = in_tvalid;
    next_index = in_tdata;
    if (!rst_n) begin
      next_valid = 1'b0;
    end else if (!in_tvalid || req_taken) begin
      next_valid = 1'b0;
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
      if (gap_left > 0) begin
        gap_left--;
      end else if (index_q.size() > 0) begin
        next_valid = 1'b1;
        next_index = index_q.pop_front();
        burst_left--;
      end
    end
    in_tvalid <= next_valid;
    in_tdata  <= next_index;
  end

  // Receiver: rotate an 8-bit stall pattern, reload it when pat_left runs out.
  always @(negedge clk) begin
    if (pat_left == 0) begin
      ready_pat = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
      pat_left  = 32;
    end
    pat_left--;
    out_tready <= ready_pat[0];
    ready_pat = {ready_pat[0], ready_pat[7:1]};
  end

  task automatic write_reg(tpsg_pkg::cfg_idx_t idx, logic [tpsg_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    case (idx)
      tpsg_pkg::CFG_PHASE_STEP:  step_cfg    = value;
      tpsg_pkg::CFG_CURRENT_LAG: lag_cfg     = value;
      tpsg_pkg::CFG_VOLT_AMP_A:  volt_amp[0] = value[tpsg_pkg::AMP_W-1:0];
      tpsg_pkg::CFG_VOLT_AMP_B:  volt_amp[1] = value[tpsg_pkg::AMP_W-1:0];
      tpsg_pkg::CFG_VOLT_AMP_C:  volt_amp[2] = value[tpsg_pkg::AMP_W-1:0];
      tpsg_pkg::CFG_CURR_AMP_A:  curr_amp[0] = value[tpsg_pkg::AMP_W-1:0];
      tpsg_pkg::CFG_CURR_AMP_B:  curr_amp[1] = value[tpsg_pkg::AMP_W-1:0];
      tpsg_pkg::CFG_CURR_AMP_C:  curr_amp[2] = value[tpsg_pkg::AMP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_all(logic [31:0] step, logic [31:0] lag,
                             logic [31:0] va, logic [31:0] vb, logic [31:0] vc,
                             logic [31:0] ia, logic [31:0] ib, logic [31:0] ic);
    write_reg(tpsg_pkg::CFG_PHASE_STEP, step);
    write_reg(tpsg_pkg::CFG_CURRENT_LAG, lag);
    write_reg(tpsg_pkg::CFG_VOLT_AMP_A, va);
    write_reg(tpsg_pkg::CFG_VOLT_AMP_B, vb);
    write_reg(tpsg_pkg::CFG_VOLT_AMP_C, vc);
    write_reg(tpsg_pkg::CFG_CURR_AMP_A, ia);
    write_reg(tpsg_pkg::CFG_CURR_AMP_B, ib);
    write_reg(tpsg_pkg::CFG_CURR_AMP_C, ic);
    @(negedge clk);
    cfg_wen <= 1'b0;
    setting_count++;
  endtask

  // Wait until every request is sent and every result has come back.
  task automatic drain();
    do begin
      @(negedge clk);
    end while (index_q.size() != 0 || in_tvalid || sample_exp_q.size() != 0);
  endtask

  function automatic logic [31:0] pick_angle();
    case ($urandom_range(0, 4))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom_range(1, 32'h0100_0000);
      default: return $urandom;
    endcase
  endfunction

  // Some picks carry junk above bit 21 to exercise masking.
  function automatic logic [31:0] pick_amp();
    case ($urandom_range(0, 4))
      0:       return 32'h0;
      1:       return 32'h003F_FFFF;
      2:       return $urandom;
      default: return $urandom_range(0, 32'h003F_FFFF);
    endcase
  endfunction

  function automatic logic [tpsg_pkg::INDEX_W-1:0] pick_index();
    logic [31:0] r;
    if ($urandom_range(0, 3) == 0) begin
      r = $urandom_range(0, 255);
    end else begin
      r = $urandom;
    end
    return r[tpsg_pkg::INDEX_W-1:0];
  endfunction

  initial begin
    fill_sine_tab();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: quadrant edges at 1/80 turn per step, index extremes, wrap.
    index_q = '{16'd0, 16'd65535, 16'd1, 16'd20, 16'd40, 16'd60, 16'd80,
                16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA, 16'h00FF};
    drain();

    // Quarter-turn steps hit the exact quadrant boundaries at full amplitude.
    program_all(32'h4000_0000, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    index_q = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'hFFFF, 16'h8000,
                16'd6, 16'd7};
    drain();

    for (int p = 0; p < 8; p++) begin
      if (p == 3) begin
        program_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0,
                    32'h003F_FFFF, 32'h0, 32'hFFC0_0000);
      end else begin
        program_all(pick_angle(), pick_angle(), pick_amp(), pick_amp(), pick_amp(),
                    pick_amp(), pick_amp(), pick_amp());
      end
      repeat (110) index_q.push_back(pick_index());
      drain();
    end

    repeat (20) @(posedge clk);
    $display("Sent %0d sample requests under %0d register settings.", req_count,
             setting_count);
    $display("Checked %0d results, %0d mismatches.", result_count, err_count);
    if (err_count == 0 && sample_exp_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timed out with %0d results still pending.", sample_exp_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
sv/tpsg_pkg.sv
sv/tpsg_sine_rom.sv
sv/three_phase_sine_generator.sv
sv/tpsg_checker.sv
test/testbench.sv
